// ----- src/ptb_pkg.sv -----
`default_nettype none
package ptb_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int ALPHABET   = 26;
	localparam int NODES      = MAX_LEN + 2;
	localparam int CHILD_SIZE = NODES * ALPHABET;
	localparam int SYM_W      = 5;
	localparam int NODE_W     = 13;
	localparam int LEN_W      = 14;
	localparam int POS_W      = 13;
	localparam int CADDR_W    = 17;
	localparam int WIDE_W     = 16;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FRD,
		ST_FTX,
		ST_FCMP,
		ST_CRD,
		ST_CCK,
		ST_CEV,
		ST_LRD,
		ST_LGOT,
		ST_ORD,
		ST_OWR,
		ST_PRD,
		ST_PGOT,
		ST_SGOT,
		ST_KGOT,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		NS_U,
		NS_CHILD,
		NS_LK,
		NS_CUR,
		NS_P,
		NS_S,
		NS_LKP
	} nsel_t;

	typedef struct packed {
		logic  accept;
		logic  find_tx;
		logic  find_cmp;
		logic  child_chk;
		logic  child_eval;
		logic  link_got;
		logic  occ_wr;
		logic  p_got;
		logic  s_got;
		logic  k_got;
		logic  fin;
		logic  out_load;
		nsel_t nsel;
	} cmd_t;

	typedef struct packed {
		logic sym_bad;
		logic full;
		logic match;
		logic child_ok;
		logic phase2;
		logic len_one;
		logic p_root;
	} sts_t;

	function automatic logic [NODE_W-1:0] node_ok(input logic [NODE_W-1:0] x);
		return (int'(x) < NODES) ? x : '0;
	endfunction

endpackage
`default_nettype wire

// ----- src/ptb_ctrl.sv -----
`default_nettype none
module ptb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire ptb_pkg::sts_t sts,
	output ptb_pkg::cmd_t      cmd
);

	ptb_pkg::state_t state_q;
	ptb_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptb_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.sym_bad || sts.full) begin
						state_d = ptb_pkg::ST_OUT;
					end else begin
						state_d = ptb_pkg::ST_FRD;
					end
				end
			end
			ptb_pkg::ST_FRD:  state_d = ptb_pkg::ST_FTX;
			ptb_pkg::ST_FTX:  state_d = ptb_pkg::ST_FCMP;
			ptb_pkg::ST_FCMP: state_d = sts.match ? ptb_pkg::ST_CRD : ptb_pkg::ST_FRD;
			ptb_pkg::ST_CRD:  state_d = ptb_pkg::ST_CCK;
			ptb_pkg::ST_CCK:  state_d = ptb_pkg::ST_CEV;
			ptb_pkg::ST_CEV: begin
				if (sts.phase2) begin
					state_d = ptb_pkg::ST_LRD;
				end else if (sts.child_ok) begin
					state_d = ptb_pkg::ST_ORD;
				end else if (sts.len_one) begin
					state_d = ptb_pkg::ST_LRD;
				end else begin
					state_d = ptb_pkg::ST_FRD;
				end
			end
			ptb_pkg::ST_LRD:  state_d = ptb_pkg::ST_LGOT;
			ptb_pkg::ST_LGOT: state_d = ptb_pkg::ST_ORD;
			ptb_pkg::ST_ORD:  state_d = ptb_pkg::ST_OWR;
			ptb_pkg::ST_OWR:  state_d = ptb_pkg::ST_PRD;
			ptb_pkg::ST_PRD:  state_d = sts.p_root ? ptb_pkg::ST_FIN : ptb_pkg::ST_PGOT;
			ptb_pkg::ST_PGOT: state_d = ptb_pkg::ST_SGOT;
			ptb_pkg::ST_SGOT: state_d = ptb_pkg::ST_KGOT;
			ptb_pkg::ST_KGOT: state_d = ptb_pkg::ST_PRD;
			ptb_pkg::ST_FIN:  state_d = ptb_pkg::ST_OUT;
			ptb_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = ptb_pkg::ST_IDLE;
				end
			end
			default: state_d = ptb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.nsel = ptb_pkg::NS_U;
		in_stall = 1'b1;
		case (state_q)
			ptb_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ptb_pkg::ST_FRD:  cmd.nsel = ptb_pkg::NS_U;
			ptb_pkg::ST_FTX:  cmd.find_tx = 1'b1;
			ptb_pkg::ST_FCMP: cmd.find_cmp = 1'b1;
			ptb_pkg::ST_CCK: begin
				cmd.child_chk = 1'b1;
				cmd.nsel      = ptb_pkg::NS_CHILD;
			end
			ptb_pkg::ST_CEV:  cmd.child_eval = 1'b1;
			ptb_pkg::ST_LRD:  cmd.nsel = ptb_pkg::NS_LK;
			ptb_pkg::ST_LGOT: cmd.link_got = 1'b1;
			ptb_pkg::ST_ORD:  cmd.nsel = ptb_pkg::NS_CUR;
			ptb_pkg::ST_OWR:  cmd.occ_wr = 1'b1;
			ptb_pkg::ST_PRD:  cmd.nsel = ptb_pkg::NS_P;
			ptb_pkg::ST_PGOT: begin
				cmd.p_got = 1'b1;
				cmd.nsel  = ptb_pkg::NS_S;
			end
			ptb_pkg::ST_SGOT: begin
				cmd.s_got = 1'b1;
				cmd.nsel  = ptb_pkg::NS_LKP;
			end
			ptb_pkg::ST_KGOT: cmd.k_got = 1'b1;
			ptb_pkg::ST_FIN:  cmd.fin = 1'b1;
			ptb_pkg::ST_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/ptb_dp.sv -----
`default_nettype none
module ptb_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ptb_pkg::cmd_t                   cmd,
	output ptb_pkg::sts_t                        sts,
	input  wire logic [ptb_pkg::SYM_W-1:0]       symbol,
	output logic                                 created_node,
	output logic [12:0]                          longest_suffix_len,
	output logic [12:0]                          suffix_node,
	output logic [12:0]                          suffix_occurrences,
	output logic [12:0]                          suffix_pal_count,
	output logic [12:0]                          min_pal_parts,
	output logic                                 store_full
);

	localparam int NW = ptb_pkg::NODE_W;
	localparam int LW = ptb_pkg::LEN_W;
	localparam int PW = ptb_pkg::POS_W;
	localparam int CW = ptb_pkg::CADDR_W;
	localparam int WW = ptb_pkg::WIDE_W;
	localparam int SW = ptb_pkg::SYM_W;

	logic [SW-1:0] text_mem [0:ptb_pkg::MAX_LEN];
	logic [NW-1:0] child_mem [0:ptb_pkg::CHILD_SIZE-1];
	logic [NW-1:0] link_mem [0:ptb_pkg::NODES-1];
	logic [LW-1:0] len_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] occ_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] cnt_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] step_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] serial_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] pbest_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] parent_mem [0:ptb_pkg::NODES-1];
	logic [SW-1:0] nsym_mem [0:ptb_pkg::NODES-1];
	logic [NW-1:0] bpp_mem [0:ptb_pkg::MAX_LEN];

	logic [PW-1:0] len_q;
	logic [NW-1:0] cursuf_q;
	logic [NW-1:0] nfree_q;

	logic [PW-1:0] n_q;
	logic [SW-1:0] sym_q;
	logic [NW-1:0] u_q;
	logic [NW-1:0] found_q;
	logic [NW-1:0] q_q;
	logic [LW-1:0] qlen_q;
	logic [NW-1:0] qlink_q;
	logic          phase2_q;
	logic          pos_ok_q;
	logic [LW-1:0] lenu_q;
	logic [NW-1:0] linku_q;
	logic [NW-1:0] c_q;
	logic [NW-1:0] lk_q;
	logic [LW-1:0] newlen_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] p_q;
	logic [NW-1:0] s_q;
	logic [NW-1:0] lkp_q;
	logic [NW-1:0] stepp_q;
	logic          idx_zero_q;
	logic [LW-1:0] best_q;

	logic          res_created_q;
	logic [12:0]   res_len_q;
	logic [12:0]   res_node_q;
	logic [12:0]   res_occ_q;
	logic [12:0]   res_cnt_q;
	logic [12:0]   res_parts_q;
	logic          res_full_q;

	logic [NW-1:0] nraddr;
	logic [NW-1:0] nraddr_q;
	logic [NW-1:0] m_link_q;
	logic [LW-1:0] m_len_q;
	logic [NW-1:0] m_occ_q;
	logic [NW-1:0] m_cnt_q;
	logic [NW-1:0] m_step_q;
	logic [NW-1:0] m_serial_q;
	logic [NW-1:0] m_pbest_q;
	logic [NW-1:0] m_parent_q;
	logic [SW-1:0] m_nsym_q;

	logic [NW-1:0] rd_link;
	logic [LW-1:0] rd_len;
	logic [NW-1:0] rd_cnt;
	logic [NW-1:0] rd_step;
	logic [NW-1:0] rd_serial;

	logic [PW-1:0] traddr;
	logic [SW-1:0] txt_q;
	logic [CW-1:0] craddr;
	logic [CW-1:0] cwaddr;
	logic [NW-1:0] child_q;
	logic [PW-1:0] braddr;
	logic [NW-1:0] bpp_q;

	logic          sym_bad;
	logic          full;
	logic [WW-1:0] pos;
	logic [WW-1:0] idx;
	logic [LW-1:0] step_new;
	logic [NW-1:0] serial_new;
	logic [NW-1:0] occ_waddr;
	logic [NW-1:0] occ_wdata;
	logic          occ_we;
	logic [NW-1:0] bpp_val;
	logic [NW-1:0] d_val;
	logic [LW-1:0] d_plus;

	assign sym_bad = int'(symbol) >= ptb_pkg::ALPHABET;
	assign full    = int'(len_q) >= ptb_pkg::MAX_LEN;

	always_comb begin
		case (cmd.nsel)
			ptb_pkg::NS_U:     nraddr = u_q;
			ptb_pkg::NS_CHILD: nraddr = ptb_pkg::node_ok(child_q);
			ptb_pkg::NS_LK:    nraddr = lk_q;
			ptb_pkg::NS_CUR:   nraddr = cur_q;
			ptb_pkg::NS_P:     nraddr = p_q;
			ptb_pkg::NS_S:     nraddr = ptb_pkg::node_ok(rd_serial);
			ptb_pkg::NS_LKP:   nraddr = lkp_q;
			default:           nraddr = u_q;
		endcase
	end

	// The two roots are constants and never live in the node memories.
	always_comb begin
		rd_link   = m_link_q;
		rd_len    = m_len_q;
		rd_cnt    = m_cnt_q;
		rd_step   = m_step_q;
		rd_serial = m_serial_q;
		if (nraddr_q < NW'(2)) begin
			rd_link   = '0;
			rd_len    = (nraddr_q == '0) ? '1 : '0;
			rd_cnt    = '0;
			rd_step   = '0;
			rd_serial = '0;
		end
	end

	assign pos = WW'(n_q) - {{(WW-LW){rd_len[LW-1]}}, rd_len} - WW'(1);
	assign idx = WW'(n_q) - {{(WW-LW){rd_len[LW-1]}}, rd_len} - WW'(stepp_q);

	always_comb begin
		if (idx[WW-1]) begin
			braddr = '0;
		end else if (idx > WW'(n_q)) begin
			braddr = n_q;
		end else begin
			braddr = idx[PW-1:0];
		end
	end

	assign traddr = pos[PW-1:0];
	assign craddr = CW'(found_q) * CW'(ptb_pkg::ALPHABET) + CW'(sym_q);
	assign cwaddr = CW'(q_q) * CW'(ptb_pkg::ALPHABET) + CW'(sym_q);

	assign step_new   = newlen_q - rd_len;
	assign serial_new = (step_new[NW-1:0] == rd_step) ? rd_serial : lk_q;

	always_comb begin
		occ_we    = cmd.link_got || cmd.occ_wr;
		occ_waddr = cmd.link_got ? nfree_q : cur_q;
		occ_wdata = cmd.link_got ? '0 : m_occ_q + NW'(1);
	end

	assign bpp_val = idx_zero_q ? '0 : bpp_q;
	always_comb begin
		d_val = bpp_val;
		if (stepp_q == rd_step && m_pbest_q < bpp_val) begin
			d_val = m_pbest_q;
		end
	end
	assign d_plus = LW'(d_val) + LW'(1);

	always_comb begin
		sts.sym_bad  = sym_bad;
		sts.full     = full;
		sts.match    = (pos_ok_q && txt_q == sym_q) || u_q == '0;
		sts.child_ok = c_q >= NW'(2) && c_q < nfree_q && m_parent_q == found_q
			&& m_nsym_q == sym_q;
		sts.phase2   = phase2_q;
		sts.len_one  = qlen_q == '1;
		sts.p_root   = p_q < NW'(2);
	end

	always_ff @(posedge clk) begin
		nraddr_q   <= nraddr;
		m_link_q   <= link_mem[nraddr];
		m_len_q    <= len_mem[nraddr];
		m_occ_q    <= occ_mem[nraddr];
		m_cnt_q    <= cnt_mem[nraddr];
		m_step_q   <= step_mem[nraddr];
		m_serial_q <= serial_mem[nraddr];
		m_pbest_q  <= pbest_mem[nraddr];
		m_parent_q <= parent_mem[nraddr];
		m_nsym_q   <= nsym_mem[nraddr];
		if (cmd.link_got) begin
			link_mem[nfree_q]   <= lk_q;
			len_mem[nfree_q]    <= newlen_q;
			cnt_mem[nfree_q]    <= rd_cnt + NW'(1);
			step_mem[nfree_q]   <= step_new[NW-1:0];
			serial_mem[nfree_q] <= serial_new;
			parent_mem[nfree_q] <= q_q;
			nsym_mem[nfree_q]   <= sym_q;
		end
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		if (cmd.k_got) begin
			pbest_mem[p_q] <= d_val;
		end
	end

	always_ff @(posedge clk) begin
		txt_q <= text_mem[traddr];
		if (cmd.accept && !sym_bad && !full) begin
			text_mem[len_q + PW'(1)] <= symbol;
		end
	end

	always_ff @(posedge clk) begin
		child_q <= child_mem[craddr];
		if (cmd.link_got) begin
			child_mem[cwaddr] <= nfree_q;
		end
	end

	always_ff @(posedge clk) begin
		bpp_q <= bpp_mem[braddr];
		if (cmd.fin) begin
			bpp_mem[n_q] <= best_q[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cursuf_q <= NW'(1);
			nfree_q  <= NW'(2);
		end else begin
			if (cmd.accept && !sym_bad && !full) begin
				len_q <= len_q + PW'(1);
			end
			if (cmd.link_got) begin
				nfree_q <= nfree_q + NW'(1);
			end
			if (cmd.occ_wr) begin
				cursuf_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q           <= len_q + PW'(1);
			sym_q         <= symbol;
			u_q           <= ptb_pkg::node_ok(cursuf_q);
			phase2_q      <= 1'b0;
			res_created_q <= 1'b0;
			res_len_q     <= '0;
			res_node_q    <= '0;
			res_occ_q     <= '0;
			res_cnt_q     <= '0;
			res_parts_q   <= '0;
			res_full_q    <= !sym_bad && full;
		end
		if (cmd.find_tx) begin
			pos_ok_q <= !pos[WW-1] && pos != '0;
			lenu_q   <= rd_len;
			linku_q  <= rd_link;
		end
		if (cmd.find_cmp) begin
			if (sts.match) begin
				found_q <= u_q;
				if (!phase2_q) begin
					q_q     <= u_q;
					qlen_q  <= lenu_q;
					qlink_q <= linku_q;
				end
			end else begin
				u_q <= ptb_pkg::node_ok(linku_q);
			end
		end
		if (cmd.child_chk) begin
			c_q <= ptb_pkg::node_ok(child_q);
		end
		if (cmd.child_eval) begin
			if (phase2_q) begin
				lk_q <= sts.child_ok ? c_q : '0;
			end else if (sts.child_ok) begin
				cur_q         <= c_q;
				res_created_q <= 1'b0;
			end else begin
				newlen_q <= qlen_q + LW'(2);
				if (sts.len_one) begin
					lk_q <= NW'(1);
				end else begin
					u_q      <= ptb_pkg::node_ok(qlink_q);
					phase2_q <= 1'b1;
				end
			end
		end
		if (cmd.link_got) begin
			cur_q         <= nfree_q;
			res_created_q <= 1'b1;
		end
		if (cmd.occ_wr) begin
			res_len_q  <= rd_len[12:0];
			res_node_q <= cur_q;
			res_occ_q  <= m_occ_q + NW'(1);
			res_cnt_q  <= rd_cnt;
			p_q        <= cur_q;
			best_q     <= '1;
		end
		if (cmd.p_got) begin
			s_q     <= ptb_pkg::node_ok(rd_serial);
			lkp_q   <= ptb_pkg::node_ok(rd_link);
			stepp_q <= rd_step;
		end
		if (cmd.s_got) begin
			idx_zero_q <= braddr == '0;
		end
		if (cmd.k_got) begin
			if (d_plus < best_q) begin
				best_q <= d_plus;
			end
			p_q <= s_q;
		end
		if (cmd.fin) begin
			res_parts_q <= best_q[12:0];
		end
		if (cmd.out_load) begin
			created_node       <= res_created_q;
			longest_suffix_len <= res_len_q;
			suffix_node        <= res_node_q;
			suffix_occurrences <= res_occ_q;
			suffix_pal_count   <= res_cnt_q;
			min_pal_parts      <= res_parts_q;
			store_full         <= res_full_q;
		end
	end

	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(nfree_q) <= len_q + PW'(2))
		else $error("node count exceeds text length plus two");

	a_node_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_got |=> nfree_q == $past(nfree_q) + NW'(1))
		else $error("node creation did not advance the free pointer");

	a_cur_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cursuf_q != '0 && cursuf_q < nfree_q)
		else $error("current suffix node is not an allocated node");

endmodule
`default_nettype wire

// ----- src/palindromic_tree_builder.sv -----
// Palindromic tree builder with minimum palindromic factorization.
// Input channel: symbol with in_valid and in_stall; a request is taken when
// in_valid is high and in_stall is low. Output channel: the result fields
// with out_valid and out_stall, one result for every request.
// A request is worked on alone. A symbol outside the alphabet or one that
// arrives with the text store full goes from idle straight to the output
// register. A normal symbol walks suffix links to find the parent and tests
// its child slot; for a new node it walks again for the suffix link (unless
// the node has length one), tests the child slot of that second walk and
// creates the node. Then it walks the serial links for the factorization;
// the walks are amortized constant. The node memories share a single read port.
// While a result waits in the output register under out_stall the next
// request is taken and worked on; it holds only at its end until the
// register is free.
// Reset empties the text and the tree at once: child slots are checked
// against the parent and symbol of the node that they name, so no memory
// clearing pass is needed.
`default_nettype none
module palindromic_tree_builder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [ptb_pkg::SYM_W-1:0] symbol,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           created_node,
	output logic [12:0]                    longest_suffix_len,
	output logic [12:0]                    suffix_node,
	output logic [12:0]                    suffix_occurrences,
	output logic [12:0]                    suffix_pal_count,
	output logic [12:0]                    min_pal_parts,
	output logic                           store_full
);

	ptb_pkg::cmd_t cmd;
	ptb_pkg::sts_t sts;

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptb_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.symbol             (symbol),
		.created_node       (created_node),
		.longest_suffix_len (longest_suffix_len),
		.suffix_node        (suffix_node),
		.suffix_occurrences (suffix_occurrences),
		.suffix_pal_count   (suffix_pal_count),
		.min_pal_parts      (min_pal_parts),
		.store_full         (store_full)
	);

endmodule
`default_nettype wire
